@@ src/bvt_pkg.sv @@
// Shared constants, codes and types of the bounded vector table.
package bvt_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;
	localparam int REQ_W  = 4;
	localparam int STAT_W = 2;

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH    = 4'd0,
		REQ_INSERT  = 4'd1,
		REQ_DELETE  = 4'd2,
		REQ_READ    = 4'd3,
		REQ_WRITE   = 4'd4,
		REQ_FIND    = 4'd5,
		REQ_REMOVE  = 4'd6,
		REQ_POP     = 4'd7,
		REQ_PREPEND = 4'd8,
		REQ_CLEAR   = 4'd9
	} req_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CK_NONE,
		CK_PUT,
		CK_INSERT,
		CK_DELETE,
		CK_DEL_FIRST,
		CK_CLEAR
	} cell_kind_t;

	typedef struct packed {
		cell_kind_t              kind;
		logic [IDX_W-1:0]        pos;
		logic [CNT_W-1:0]        count;
		logic [DATA_W-1:0]       val;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_RMV
	} fsm_state_t;

endpackage

@@ src/bvt_ifs.sv @@
// Request, response and configuration channel interfaces.
interface bvt_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [bvt_pkg::REQ_W-1:0]             req_type;
	logic [bvt_pkg::IDX_W-1:0]             position;
	logic signed [bvt_pkg::DATA_W-1:0]     operand_value;

	modport source (output valid, output req_type, output position, output operand_value,
		input ready);
	modport sink (input valid, input req_type, input position, input operand_value,
		output ready);
endinterface

interface bvt_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [bvt_pkg::STAT_W-1:0]            status;
	logic signed [bvt_pkg::DATA_W-1:0]     result_data;
	logic [bvt_pkg::CNT_W-1:0]             element_count;

	modport source (output valid, output status, output result_data, output element_count,
		input ready);
	modport sink (input valid, input status, input result_data, input element_count,
		output ready);
endinterface

interface bvt_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [bvt_pkg::CNT_W-1:0]             capacity_limit;

	modport source (output valid, output capacity_limit, input ready);
	modport sink (input valid, input capacity_limit, output ready);
endinterface

@@ src/bvt_cell.sv @@
// One list entry: holds a word, matches it against the operand and shifts it.
module bvt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [bvt_pkg::IDX_W-1:0]      idx,
	input  bvt_pkg::cell_cmd_t             cmd,
	input  logic [bvt_pkg::DATA_W-1:0]     left_in,
	input  logic [bvt_pkg::DATA_W-1:0]     right_in,
	input  logic                           seen_in,
	output logic [bvt_pkg::DATA_W-1:0]     data,
	output logic                           match,
	output logic                           seen_out
);

	logic [bvt_pkg::DATA_W-1:0] data_q;
	logic [bvt_pkg::DATA_W-1:0] data_d;
	logic                       in_use;

	assign in_use   = {1'b0, idx} < cmd.count;
	assign match    = in_use && (data_q == cmd.val);
	assign seen_out = seen_in | match;
	assign data     = data_q;

	always_comb begin
		data_d = data_q;
		case (cmd.kind)
			bvt_pkg::CK_PUT: begin
				if (idx == cmd.pos) data_d = cmd.val;
			end
			bvt_pkg::CK_INSERT: begin
				if (idx == cmd.pos) data_d = cmd.val;
				else if (idx > cmd.pos) data_d = left_in;
			end
			bvt_pkg::CK_DELETE: begin
				if (idx >= cmd.pos) data_d = right_in;
			end
			// close the gap left by the first matching entry
			bvt_pkg::CK_DEL_FIRST: begin
				if (seen_out) data_d = right_in;
			end
			bvt_pkg::CK_CLEAR: begin
				data_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else data_q <= data_d;
	end

endmodule

@@ src/bvt_chain.sv @@
// Row of list cells with the read select and first-match encoder.
module bvt_chain (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bvt_pkg::cell_cmd_t             cmd,
	output logic [bvt_pkg::DATA_W-1:0]     rd_data,
	output logic                           any_match,
	output logic [bvt_pkg::IDX_W-1:0]      first_idx
);

	logic [bvt_pkg::DATA_W-1:0] data_w [bvt_pkg::DEPTH];
	logic [bvt_pkg::DEPTH-1:0]  match_w;
	logic [bvt_pkg::DEPTH:0]    seen_w;

	assign seen_w[0] = 1'b0;

	for (genvar i = 0; i < bvt_pkg::DEPTH; i++) begin : g_cell
		logic [bvt_pkg::DATA_W-1:0] left_w;
		logic [bvt_pkg::DATA_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = data_w[i-1];
		end
		if (i == bvt_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = data_w[i+1];
		end

		bvt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (bvt_pkg::IDX_W'(i)),
			.cmd      (cmd),
			.left_in  (left_w),
			.right_in (right_w),
			.seen_in  (seen_w[i]),
			.data     (data_w[i]),
			.match    (match_w[i]),
			.seen_out (seen_w[i+1])
		);
	end

	assign any_match = seen_w[bvt_pkg::DEPTH];

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < bvt_pkg::DEPTH; i++) begin
			if (cmd.pos == bvt_pkg::IDX_W'(i)) rd_data = rd_data | data_w[i];
		end
	end

	// lowest matching index wins
	always_comb begin
		first_idx = '0;
		for (int i = bvt_pkg::DEPTH - 1; i >= 0; i--) begin
			if (match_w[i]) first_idx = bvt_pkg::IDX_W'(i);
		end
	end

endmodule

@@ src/bounded_vector_table.sv @@
// Top level of the bounded vector table: request control, count and result register.
//
// Usage: an ordered list of up to 64 signed 32-bit words. Send one request beat on
// req (req_type, position, operand_value); one response beat follows on rsp with
// status, result_data and element_count after the request.
// cfg writes capacity_limit (0 acts as 1, above 64 acts as 64); write it only while
// no request is pending. cfg.ready is always high.
// A response is registered from S_EXEC after its request beat, or later while
// the output register still holds an unaccepted response. Remove-all goes on from
// S_EXEC to S_RMV and answers once no copy is left; the cell row closes one gap per
// cycle, so it occupies the block longer for every copy removed. req.ready is high
// only while the block is idle, so one request is in work.
// A waiting response does not block the next request beat; the block holds its
// result, and but for remove-all the list, until rsp.ready frees the output register.
// Reset: the list is empty, every cell reads zero and capacity_limit is 64. No
// clearing pass is needed after reset.
module bounded_vector_table (
	input  logic  clk,
	input  logic  arst_n,
	bvt_req_if.sink   req,
	bvt_rsp_if.source rsp,
	bvt_cfg_if.sink   cfg
);

	bvt_pkg::fsm_state_t                state_q, state_d;
	logic [bvt_pkg::CNT_W-1:0]          cap_q;
	logic [bvt_pkg::CNT_W-1:0]          cap_eff;
	logic [bvt_pkg::CNT_W-1:0]          count_q, count_d;
	logic [bvt_pkg::CNT_W-1:0]          removed_q, removed_d;
	logic [bvt_pkg::REQ_W-1:0]          req_s1;
	logic [bvt_pkg::IDX_W-1:0]          pos_s1;
	logic [bvt_pkg::DATA_W-1:0]         val_s1;
	logic                               out_valid_q;
	logic [bvt_pkg::STAT_W-1:0]         out_status_q;
	logic [bvt_pkg::DATA_W-1:0]         out_data_q;
	logic [bvt_pkg::CNT_W-1:0]          out_count_q;
	logic                               out_load;
	bvt_pkg::status_t                   res_status;
	logic [bvt_pkg::DATA_W-1:0]         res_data;
	logic                               out_free;
	logic                               full;
	bvt_pkg::cell_cmd_t                 cmd;
	logic [bvt_pkg::DATA_W-1:0]         rd_data;
	logic                               any_match;
	logic [bvt_pkg::IDX_W-1:0]          first_idx;

	assign req.ready = (state_q == bvt_pkg::S_IDLE);
	assign cfg.ready = 1'b1;

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.result_data   = out_data_q;
	assign rsp.element_count = out_count_q;

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		if (cap_q == '0) cap_eff = bvt_pkg::CNT_W'(1);
		else if (cap_q > bvt_pkg::CNT_W'(bvt_pkg::DEPTH)) cap_eff = bvt_pkg::CNT_W'(bvt_pkg::DEPTH);
		else cap_eff = cap_q;
	end

	assign full = count_q >= cap_eff;

	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		removed_d  = removed_q;
		out_load   = 1'b0;
		res_status = bvt_pkg::ST_OK;
		res_data   = '0;
		cmd.kind   = bvt_pkg::CK_NONE;
		cmd.pos    = pos_s1;
		cmd.count  = count_q;
		cmd.val    = val_s1;

		unique case (state_q)
			bvt_pkg::S_IDLE: begin
				if (req.valid) state_d = bvt_pkg::S_EXEC;
			end
			bvt_pkg::S_EXEC: begin
				case (req_s1)
					bvt_pkg::REQ_PUSH: cmd.pos = count_q[bvt_pkg::IDX_W-1:0];
					bvt_pkg::REQ_PREPEND: cmd.pos = '0;
					bvt_pkg::REQ_POP: cmd.pos = bvt_pkg::IDX_W'(count_q - bvt_pkg::CNT_W'(1));
					default: ;
				endcase
				if (req_s1 == bvt_pkg::REQ_REMOVE) begin
					removed_d = '0;
					state_d   = bvt_pkg::S_RMV;
				end else if (out_free) begin
					out_load = 1'b1;
					state_d  = bvt_pkg::S_IDLE;
					unique case (req_s1) inside
						bvt_pkg::REQ_PUSH, bvt_pkg::REQ_PREPEND: begin
							if (full) begin
								res_status = bvt_pkg::ST_FULL;
							end else begin
								cmd.kind = (req_s1 == bvt_pkg::REQ_PUSH) ?
									bvt_pkg::CK_PUT : bvt_pkg::CK_INSERT;
								count_d  = count_q + bvt_pkg::CNT_W'(1);
							end
						end
						bvt_pkg::REQ_INSERT: begin
							if ({1'b0, pos_s1} > count_q) begin
								res_status = bvt_pkg::ST_RANGE;
							end else if (full) begin
								res_status = bvt_pkg::ST_FULL;
							end else begin
								cmd.kind = bvt_pkg::CK_INSERT;
								count_d  = count_q + bvt_pkg::CNT_W'(1);
							end
						end
						bvt_pkg::REQ_DELETE: begin
							if ({1'b0, pos_s1} >= count_q) begin
								res_status = bvt_pkg::ST_RANGE;
							end else begin
								cmd.kind = bvt_pkg::CK_DELETE;
								count_d  = count_q - bvt_pkg::CNT_W'(1);
							end
						end
						bvt_pkg::REQ_READ: begin
							if ({1'b0, pos_s1} >= count_q) res_status = bvt_pkg::ST_RANGE;
							else res_data = rd_data;
						end
						bvt_pkg::REQ_WRITE: begin
							if ({1'b0, pos_s1} >= count_q) res_status = bvt_pkg::ST_RANGE;
							else cmd.kind = bvt_pkg::CK_PUT;
						end
						bvt_pkg::REQ_FIND: begin
							res_data = any_match ? bvt_pkg::DATA_W'(first_idx) : '1;
						end
						bvt_pkg::REQ_POP: begin
							if (count_q == '0) begin
								res_status = bvt_pkg::ST_EMPTY;
							end else begin
								// shift the zero above the tail into the vacated entry
								cmd.kind = bvt_pkg::CK_DELETE;
								res_data = rd_data;
								count_d  = count_q - bvt_pkg::CNT_W'(1);
							end
						end
						bvt_pkg::REQ_CLEAR: begin
							cmd.kind = bvt_pkg::CK_CLEAR;
							count_d  = '0;
						end
						default: ;
					endcase
				end
			end
			bvt_pkg::S_RMV: begin
				// drop one copy per cycle until none is left
				if (any_match) begin
					cmd.kind  = bvt_pkg::CK_DEL_FIRST;
					count_d   = count_q - bvt_pkg::CNT_W'(1);
					removed_d = removed_q + bvt_pkg::CNT_W'(1);
				end else if (out_free) begin
					out_load = 1'b1;
					res_data = bvt_pkg::DATA_W'(removed_q);
					state_d  = bvt_pkg::S_IDLE;
				end
			end
			default: state_d = bvt_pkg::S_IDLE;
		endcase
	end

	bvt_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_data   (rd_data),
		.any_match (any_match),
		.first_idx (first_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bvt_pkg::S_IDLE;
			count_q     <= '0;
			removed_q   <= '0;
			cap_q       <= bvt_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			removed_q <= removed_d;
			if (cfg.valid) cap_q <= cfg.capacity_limit;
			if (out_load) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.req_type;
			pos_s1 <= req.position;
			val_s1 <= req.operand_value;
		end
		if (out_load) begin
			out_status_q <= res_status;
			out_data_q   <= res_data;
			out_count_q  <= count_d;
		end
	end

endmodule
